/* sv/phmm_pkg.sv */
package phmm_pkg;

  localparam int MAX_STATES = 8;
  localparam int SW = 3;
  localparam int VW = 32;
  localparam int EW = 16;
  localparam int ACCW = 37;
  localparam logic [VW-1:0] UNIT_ONE = 32'h4000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD_TRANS = 2'd0,
    CMD_LOAD_START = 2'd1,
    CMD_PROCESS    = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_COLUMN_COUNT  = 3'd0,
    CFG_ROW_COUNT     = 3'd1,
    CFG_STATE_COUNT   = 3'd2,
    CFG_FIRST_MASK    = 3'd3,
    CFG_SECOND_MASK   = 3'd4,
    CFG_RESCALE_CUT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SETUP,
    ST_SCAN,
    ST_MAC,
    ST_EMIT,
    ST_ALIGN,
    ST_NORM,
    ST_KSET,
    ST_SCALE,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DIAG,
    SRC_UP,
    SRC_LEFT,
    SRC_CUR
  } src_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } arith_ctl_t;

endpackage

/* sv/phmm_ram.sv */
module phmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/phmm_arith.sv */
module phmm_arith (
  input  logic                      clk,
  input  phmm_pkg::arith_ctl_t      ctl,
  input  logic [phmm_pkg::VW-1:0]   a,
  input  logic [phmm_pkg::VW-1:0]   b,
  output logic [2*phmm_pkg::VW-1:0] prod,
  output logic [phmm_pkg::ACCW-1:0] acc
);
  import phmm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + ACCW'(prod[2*VW-1:30]);
    end
  end

endmodule

/* sv/pair_hmm_forward_fill_core.sv */
// pair-hmm forward fill core
// item channel (item_valid / item_stall) takes one word per command: load transition,
// load start value, or process the next cell of the grid in row-major order.
// load commands are taken in the idle state. a process command walks the cell with one
// shared multiplier: a fetch phase, a setup step, a multiply-accumulate pass for each
// of the n states in use whose predecessor is on the grid (one whose predecessor is off
// it is skipped), a closing step, a rescale pass when the largest value is nonzero and
// below the cutoff, a write phase and then n result words; output stalls lengthen it.
// the multiply-accumulate loop runs through the single multiplier.
// result channel (result_valid / result_stall) gives one word per state; the last
// word of a cell has last_of_cell set. item_stall stays high until the last result
// word is taken, so a stalled receiver simply holds the core.
// configuration writes (cfg_valid / cfg_ready) are always taken and must be done idle.
// after reset the row memories are swept to zero while item_stall is high; configuration
// writes are still taken then.
module pair_hmm_forward_fill_core #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [2:0]         from_state,
  input  logic [2:0]         to_state,
  input  logic [31:0]        load_value,
  input  logic [31:0]        emit_both,
  input  logic [31:0]        emit_first,
  input  logic [31:0]        emit_second,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         state_index,
  output logic [31:0]        forward_value,
  output logic signed [15:0] cell_exponent,
  output logic               last_of_cell,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import phmm_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = CW + SW;
  localparam logic [RW-1:0] CLR_LAST = RW'(MAX_COLUMNS * MAX_STATES - 1);
  localparam logic [16:0] LAST_MAX = 17'(MAX_COLUMNS - 1);

  function automatic logic [VW-1:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? '1 : v[31:0];
  endfunction

  state_t state, state_next;

  logic [9:0]  column_count;
  logic [15:0] row_count;
  logic [3:0]  state_count;
  logic [7:0]  first_mask, second_mask;
  logic [31:0] cutoff;

  logic [VW-1:0] up_r [MAX_STATES];
  logic [VW-1:0] left_r [MAX_STATES];
  logic [VW-1:0] cur [MAX_STATES];
  logic [VW-1:0] origin [MAX_STATES];
  logic [VW-1:0] diag [MAX_STATES];
  logic signed [EW-1:0] up_exp, left_exp, diag_exp, exp_r, src_exp;
  logic [VW-1:0] e_both, e_first, e_second, emis, maxv, nx;
  src_t src_sel;
  logic [4:0] cnt, p;
  logic [3:0] s1, s2;
  logic [2:0] i1;
  logic v1, v2;
  logic signed [5:0] k;
  logic [15:0] row_pos;
  logic [CW-1:0] col_pos, last_col;
  logic [RW-1:0] clr_addr;

  logic [3:0] n4;
  logic has_up, has_left, accept;

  logic          row_we, exp_we, tr_we;
  logic [RW-1:0] row_waddr, row_raddr;
  logic [VW-1:0] row_wdata, row_rdata;
  logic [CW-1:0] exp_waddr, exp_raddr;
  logic [EW-1:0] exp_wdata, exp_rdata;
  logic [VW-1:0] tr_rdata;

  arith_ctl_t    actl;
  logic [VW-1:0] ma, mb, src_val;
  logic [2*VW-1:0] prod;
  logic [ACCW-1:0] acc;

  logic signed [EW-1:0] exp_calc;
  logic signed [16:0]   d, exp_k;
  logic [33:0]          t, t_sh;
  logic [VW-1:0]        v_new, scaled;
  logic [63:0]          wide;
  logic [4:0]           sh;
  logic                 di, dj, skip;
  src_t                 sel_new;
  logic signed [EW-1:0] sexp_new;
  logic [VW-1:0]        emis_new;

  phmm_ram #(.WIDTH(VW), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
    .clk(clk), .we(tr_we), .waddr({from_state, to_state}), .wdata(load_value),
    .raddr({s1[2:0], s2[2:0]}), .rdata(tr_rdata)
  );

  phmm_ram #(.WIDTH(VW), .DEPTH(MAX_COLUMNS * MAX_STATES)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  phmm_ram #(.WIDTH(EW), .DEPTH(MAX_COLUMNS)) u_exp (
    .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
    .raddr(exp_raddr), .rdata(exp_rdata)
  );

  phmm_arith u_arith (
    .clk(clk), .ctl(actl), .a(ma), .b(mb), .prod(prod), .acc(acc)
  );

  assign n4 = (state_count < 4'd2) ? 4'd2 : (state_count > 4'd8) ? 4'd8 : state_count;
  assign has_up = row_pos != '0;
  assign has_left = col_pos != '0;
  assign last_col = (17'(column_count) > LAST_MAX) ? CW'(LAST_MAX) : CW'(column_count);
  assign accept = item_valid && (state == ST_IDLE);
  assign item_stall = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  assign result_valid = state == ST_OUT;
  assign state_index = cnt[2:0];
  assign forward_value = cur[cnt[2:0]];
  assign cell_exponent = exp_r;
  assign last_of_cell = cnt[3:0] == n4 - 4'd1;

  // neighbour scale
  always_comb begin
    exp_calc = '0;
    if (has_up && has_left) begin
      exp_calc = up_exp;
      if (diag_exp > exp_calc) exp_calc = diag_exp;
      if (left_exp > exp_calc) exp_calc = left_exp;
    end else if (has_up) begin
      exp_calc = up_exp;
    end else if (has_left) begin
      exp_calc = left_exp;
    end
  end

  // move of the next state
  always_comb begin
    di = first_mask[s2[2:0]];
    dj = second_mask[s2[2:0]];
    skip = 1'b0;
    sel_new = SRC_CUR;
    sexp_new = exp_r;
    emis_new = UNIT_ONE;
    if (di && dj) begin
      skip = !has_up || !has_left;
      sel_new = SRC_DIAG;
      sexp_new = diag_exp;
      emis_new = e_both;
    end else if (di) begin
      skip = !has_up;
      sel_new = SRC_UP;
      sexp_new = up_exp;
      emis_new = e_first;
    end else if (dj) begin
      skip = !has_left;
      sel_new = SRC_LEFT;
      sexp_new = left_exp;
      emis_new = e_second;
    end
  end

  always_comb begin
    case (src_sel)
      SRC_DIAG: src_val = diag[i1];
      SRC_UP:   src_val = up_r[i1];
      SRC_LEFT: src_val = left_r[i1];
      default:  src_val = cur[i1];
    endcase
  end

  // alignment and rescale shifts
  always_comb begin
    t = prod[63:30];
    d = 17'(exp_r) - 17'(src_exp);
    if (d >= 17'sd32) t_sh = '0;
    else if (d > 17'sd0) t_sh = t >> d[4:0];
    else t_sh = t;
    v_new = sat32(64'(t_sh));
    sh = 5'd16 >> cnt[2:0];
    wide = 64'(cur[cnt[2:0]]) << k[4:0];
    scaled = (k >= 6'sd0) ? sat32(wide) : (cur[cnt[2:0]] >> 1);
    exp_k = 17'(exp_r) - 17'(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tr_we = 1'b0;
    row_we = 1'b0;
    exp_we = 1'b0;
    row_waddr = {col_pos, cnt[2:0]};
    row_wdata = cur[cnt[2:0]];
    row_raddr = (cnt < 5'd8) ? {col_pos, cnt[2:0]} : {col_pos - CW'(1), cnt[2:0]};
    exp_waddr = col_pos;
    exp_wdata = exp_r;
    exp_raddr = (cnt == 5'd0) ? col_pos : col_pos - CW'(1);
    actl = '0;
    ma = src_val;
    mb = tr_rdata;
    case (state)
      ST_CLEAR: begin
        row_we = 1'b1;
        exp_we = 1'b1;
        row_waddr = clr_addr;
        row_wdata = '0;
        exp_waddr = clr_addr[RW-1:SW];
        exp_wdata = '0;
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          tr_we = command == CMD_LOAD_TRANS;
          if (command == CMD_PROCESS) state_next = ST_FETCH;
        end
      end
      ST_FETCH: if (cnt == 5'd16) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (s2 == n4) begin
          state_next = (maxv != '0 && maxv < cutoff) ? ST_NORM : ST_WRITE;
        end else if (!skip) begin
          actl.acc_clr = 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        actl.mul_en = v1;
        actl.acc_en = v2;
        if (s1 == n4 && !v1 && !v2) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        actl.mul_en = 1'b1;
        ma = sat32(64'(acc));
        mb = emis;
        state_next = ST_ALIGN;
      end
      ST_ALIGN: state_next = ST_SCAN;
      ST_NORM: if (cnt == 5'd4) state_next = ST_KSET;
      ST_KSET: state_next = ST_SCALE;
      ST_SCALE: if (cnt[3:0] == n4 - 4'd1) state_next = ST_WRITE;
      ST_WRITE: begin
        row_we = 1'b1;
        exp_we = cnt == 5'd0;
        if (cnt == 5'd7) state_next = ST_OUT;
      end
      ST_OUT: if (!result_stall && last_of_cell) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      state_count <= 4'd5;
      first_mask <= '0;
      second_mask <= '0;
      cutoff <= 32'd4194304;
      clr_addr <= '0;
      row_pos <= '0;
      col_pos <= '0;
      diag_exp <= '0;
      cnt <= '0;
      for (int s = 0; s < MAX_STATES; s++) begin
        origin[s] <= '0;
        diag[s] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COLUMN_COUNT: column_count <= cfg_data[9:0];
          CFG_ROW_COUNT:    row_count <= cfg_data[15:0];
          CFG_STATE_COUNT:  state_count <= cfg_data[3:0];
          CFG_FIRST_MASK:   first_mask <= cfg_data[7:0];
          CFG_SECOND_MASK:  second_mask <= cfg_data[7:0];
          CFG_RESCALE_CUT:  cutoff <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + RW'(1);
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (command == CMD_LOAD_START) origin[from_state] <= load_value;
            e_both <= emit_both;
            e_first <= emit_first;
            e_second <= emit_second;
          end
        end
        ST_FETCH: begin
          if (cnt != 5'd0) begin
            if (cnt <= 5'd8) up_r[3'(cnt - 5'd1)] <= row_rdata;
            else left_r[3'(cnt - 5'd1)] <= row_rdata;
          end
          if (cnt == 5'd1) up_exp <= exp_rdata;
          if (cnt == 5'd2) left_exp <= exp_rdata;
          cnt <= cnt + 5'd1;
        end
        ST_SETUP: begin
          exp_r <= exp_calc;
          maxv <= '0;
          s2 <= '0;
          for (int s = 0; s < MAX_STATES; s++) begin
            cur[s] <= (!has_up && !has_left) ? origin[s] : '0;
          end
        end
        ST_SCAN: begin
          cnt <= '0;
          nx <= maxv;
          p <= '0;
          if (s2 != n4) begin
            if (skip) begin
              s2 <= s2 + 4'd1;
            end else begin
              src_sel <= sel_new;
              src_exp <= sexp_new;
              emis <= emis_new;
              s1 <= '0;
              v1 <= 1'b0;
              v2 <= 1'b0;
            end
          end
        end
        ST_MAC: begin
          v1 <= s1 < n4;
          i1 <= s1[2:0];
          v2 <= v1;
          if (s1 < n4) s1 <= s1 + 4'd1;
        end
        ST_ALIGN: begin
          cur[s2[2:0]] <= v_new;
          if (v_new > maxv) maxv <= v_new;
          s2 <= s2 + 4'd1;
        end
        ST_NORM: begin
          if ((nx >> sh) != '0) begin
            nx <= nx >> sh;
            p <= p + sh;
          end
          cnt <= cnt + 5'd1;
        end
        ST_KSET: begin
          cnt <= '0;
          if (maxv >= UNIT_ONE || (maxv & (maxv - 32'd1)) == '0) k <= 6'sd30 - 6'(p);
          else k <= 6'sd29 - 6'(p);
        end
        ST_SCALE: begin
          cur[cnt[2:0]] <= scaled;
          if (cnt[3:0] == n4 - 4'd1) begin
            cnt <= '0;
            if (exp_k > 17'sd32767) exp_r <= 16'sd32767;
            else if (exp_k < -17'sd32768) exp_r <= -16'sd32768;
            else exp_r <= exp_k[15:0];
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_WRITE: begin
          if (cnt == 5'd7) begin
            cnt <= '0;
            for (int s = 0; s < MAX_STATES; s++) diag[s] <= up_r[s];
            diag_exp <= up_exp;
            if (col_pos >= last_col) begin
              col_pos <= '0;
              row_pos <= (row_pos >= row_count) ? '0 : row_pos + 16'd1;
            end else begin
              col_pos <= col_pos + CW'(1);
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_OUT: if (!result_stall) cnt <= cnt + 5'd1;
        default: ;
      endcase
    end
  end

endmodule
